// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file, which checks its own behavior.
// No dependencies; take in by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/plt_pkg.sv =====
// Shared types and constants for the piecewise linear table lookup.
// No dependencies; imported by the controller, datapath and top level.
package plt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Interpolation arithmetic widths
	localparam int DIFF_W = 17;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int MAG_W = PROD_W - 1;
	localparam int REM_W = DIFF_W + 1;
	localparam int SUM_W = MAG_W + 2;
	localparam int DCNT_W = $clog2(MAG_W);

	// Opcodes
	localparam logic [1:0] OPC_LOAD = 2'd0;
	localparam logic [1:0] OPC_CLEAR = 2'd1;
	localparam logic [1:0] OPC_QUERY = 2'd2;

	// Status codes
	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_INTERP = 3'd1;
	localparam logic [2:0] ST_EXACT = 3'd2;
	localparam logic [2:0] ST_OOB = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SORT_INIT,
		S_SORT_CHK,
		S_SORT_SCAN,
		S_SWAP_A,
		S_SWAP_B,
		S_QRY_INIT,
		S_QRY_SCAN,
		S_EVAL,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_SUM,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_SORT_INIT,
		CMD_SORT_CHK,
		CMD_SORT_SCAN,
		CMD_SWAP_A,
		CMD_SWAP_B,
		CMD_QRY_INIT,
		CMD_QRY_SCAN,
		CMD_EVAL,
		CMD_MUL,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_SUM,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic ready;
	} ctrl_t;

	typedef struct packed {
		logic start_query;
		logic need_sort;
		logic sort_more;
		logic scan_last;
		logic interp;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hdl/plt_ctrl.sv =====
// Controller state machine for the piecewise linear table lookup.
// Depends on plt_pkg; drives the datapath through command and status structs.
module plt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  plt_pkg::dp_stat_t stat,
	output plt_pkg::ctrl_t    ctrl
);
	import plt_pkg::*;

	state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && stat.out_free && stat.start_query) begin
					state_d = stat.need_sort ? S_SORT_INIT : S_QRY_INIT;
				end
			end
			S_SORT_INIT: state_d = S_SORT_CHK;
			S_SORT_CHK:  state_d = stat.sort_more ? S_SORT_SCAN : S_QRY_INIT;
			S_SORT_SCAN: if (stat.scan_last) state_d = S_SWAP_A;
			S_SWAP_A:    state_d = S_SWAP_B;
			S_SWAP_B:    state_d = S_SORT_CHK;
			S_QRY_INIT:  state_d = S_QRY_SCAN;
			S_QRY_SCAN:  if (stat.scan_last) state_d = S_EVAL;
			S_EVAL:      state_d = stat.interp ? S_MUL : S_FIN;
			S_MUL:       state_d = S_DIV_INIT;
			S_DIV_INIT:  state_d = S_DIV;
			S_DIV:       if (stat.div_last) state_d = S_SUM;
			S_SUM:       state_d = S_FIN;
			S_FIN:       if (stat.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		ctrl.ready = 1'b0;
		ctrl.cmd = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				ctrl.ready = stat.out_free;
				if (in_valid && stat.out_free) ctrl.cmd = CMD_ACCEPT;
			end
			S_SORT_INIT: ctrl.cmd = CMD_SORT_INIT;
			S_SORT_CHK:  ctrl.cmd = CMD_SORT_CHK;
			S_SORT_SCAN: ctrl.cmd = CMD_SORT_SCAN;
			S_SWAP_A:    ctrl.cmd = CMD_SWAP_A;
			S_SWAP_B:    ctrl.cmd = CMD_SWAP_B;
			S_QRY_INIT:  ctrl.cmd = CMD_QRY_INIT;
			S_QRY_SCAN:  ctrl.cmd = CMD_QRY_SCAN;
			S_EVAL:      ctrl.cmd = CMD_EVAL;
			S_MUL:       ctrl.cmd = CMD_MUL;
			S_DIV_INIT:  ctrl.cmd = CMD_DIV_INIT;
			S_DIV:       ctrl.cmd = CMD_DIV_STEP;
			S_SUM:       ctrl.cmd = CMD_SUM;
			S_FIN:       if (stat.out_free) ctrl.cmd = CMD_FINISH;
			default:     ctrl.cmd = CMD_NONE;
		endcase
	end

endmodule

// ===== hdl/plt_dp.sv =====
// Datapath for the piecewise linear table lookup: table memory, sort and
// search scans, multiplier, serial divider and output register. Uses plt_pkg.
module plt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  plt_pkg::ctrl_t     ctrl,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] entry_key,
	input  logic signed [15:0] entry_value,
	input  logic signed [15:0] query_key,
	input  logic               out_ready,
	output plt_pkg::dp_stat_t  stat,
	output logic               out_valid,
	output logic signed [15:0] result_value,
	output logic [2:0]         status,
	output logic               saturated
);
	import plt_pkg::*;

	// Table memory: pair {value, key}
	logic [31:0] mem [TABLE_DEPTH];

	logic [CNT_W-1:0]  cnt_q;
	logic              sorted_q;
	logic signed [15:0] last_key_q;
	logic [31:0]       rd_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_v_q;
	logic [CNT_W-1:0]  j_q;
	logic [IDX_W-1:0]  i_q;
	logic signed [15:0] qk_q;
	logic [31:0]       min_q, old_q;
	logic [IDX_W-1:0]  m_q;
	logic              oob_q, exact_q, hi_f_q;
	logic signed [15:0] exact_v_q, lo_k_q, lo_v_q, hi_k_q, hi_v_q;
	logic signed [DIFF_W-1:0] dq_q, dv_q;
	logic [DIFF_W-1:0] den_q;
	logic signed [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [MAG_W-1:0]  dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic signed [15:0] res_val_q;
	logic [2:0]        res_st_q;
	logic              res_sat_q;
	logic              out_v_q;
	logic signed [15:0] out_val_q;
	logic [2:0]        out_st_q;
	logic              out_sat_q;

	logic              accept, full, do_load, rd_en, we;
	logic [IDX_W-1:0]  wa;
	logic [31:0]       wd;
	logic signed [15:0] rk, rv, mk;
	logic [REM_W-1:0]  trial;
	logic              tbit;
	logic signed [SUM_W-1:0] sq, rsum;
	logic [CNT_W-1:0]  last_idx;

	assign accept = (ctrl.cmd == CMD_ACCEPT);
	assign full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign do_load = accept && (opcode == OPC_LOAD) && !full;
	assign rd_en = ((ctrl.cmd == CMD_SORT_SCAN) || (ctrl.cmd == CMD_QRY_SCAN)) && (j_q < cnt_q);
	assign rk = rd_q[15:0];
	assign rv = rd_q[31:16];
	assign mk = min_q[15:0];
	assign last_idx = cnt_q - CNT_W'(1);

	// Status to controller
	assign stat.start_query = (opcode == OPC_QUERY) && (cnt_q != '0);
	assign stat.need_sort = !sorted_q;
	assign stat.sort_more = ({1'b0, i_q} + CNT_W'(1)) < cnt_q;
	assign stat.scan_last = rd_v_q && ({1'b0, rd_idx_q} == last_idx);
	assign stat.interp = !oob_q && !exact_q;
	assign stat.div_last = (dcnt_q == DCNT_W'(MAG_W - 1));
	assign stat.out_free = !out_v_q || out_ready;

	// Select memory write
	always_comb begin
		we = 1'b0;
		wa = cnt_q[IDX_W-1:0];
		wd = {entry_value, entry_key};
		priority if (do_load) begin
			we = 1'b1;
		end else if (ctrl.cmd == CMD_SWAP_A) begin
			we = 1'b1;
			wa = i_q;
			wd = min_q;
		end else if (ctrl.cmd == CMD_SWAP_B) begin
			we = 1'b1;
			wa = m_q;
			wd = old_q;
		end
	end

	// Memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) begin
			rd_q <= mem[j_q[IDX_W-1:0]];
			rd_idx_q <= j_q[IDX_W-1:0];
		end
	end

	// Divider step
	assign trial = {rem_q[REM_W-2:0], dvd_q[MAG_W-1]};
	assign tbit = (trial >= {1'b0, den_q});

	// Final sum of base value and signed quotient
	assign sq = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
	assign rsum = sq + SUM_W'(lo_v_q);

	// Control state: table fill, order flag, read valid, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sorted_q <= 1'b1;
			rd_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_q <= rd_en;
			if (do_load) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if ((cnt_q != '0) && (entry_key < last_key_q)) sorted_q <= 1'b0;
			end
			if (accept && (opcode == OPC_CLEAR)) begin
				cnt_q <= '0;
				sorted_q <= 1'b1;
			end
			if (ctrl.cmd == CMD_QRY_INIT) sorted_q <= 1'b1;
			if (accept && !stat.start_query) begin
				out_v_q <= 1'b1;
			end else if (ctrl.cmd == CMD_FINISH) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload: scans, arithmetic and result
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CMD_ACCEPT: begin
				qk_q <= query_key;
				if (do_load) last_key_q <= entry_key;
				out_val_q <= '0;
				out_sat_q <= 1'b0;
				if (opcode == OPC_LOAD) begin
					out_st_q <= full ? ST_FULL : ST_DONE;
				end else if (opcode == OPC_QUERY) begin
					out_st_q <= ST_EMPTY;
				end else begin
					out_st_q <= ST_DONE;
				end
			end
			CMD_SORT_INIT: i_q <= '0;
			CMD_SORT_CHK: j_q <= {1'b0, i_q};
			CMD_SORT_SCAN: begin
				if (rd_en) j_q <= j_q + CNT_W'(1);
				if (rd_v_q) begin
					if (rd_idx_q == i_q) begin
						min_q <= rd_q;
						old_q <= rd_q;
						m_q <= i_q;
					end else if (rk < mk) begin
						min_q <= rd_q;
						m_q <= rd_idx_q;
					end
				end
			end
			CMD_SWAP_B: i_q <= i_q + IDX_W'(1);
			CMD_QRY_INIT: begin
				j_q <= '0;
				oob_q <= 1'b0;
				exact_q <= 1'b0;
				hi_f_q <= 1'b0;
			end
			CMD_QRY_SCAN: begin
				if (rd_en) j_q <= j_q + CNT_W'(1);
				if (rd_v_q) begin
					if ((rd_idx_q == '0) && (qk_q < rk)) oob_q <= 1'b1;
					if (({1'b0, rd_idx_q} == last_idx) && (qk_q > rk)) oob_q <= 1'b1;
					// Track the key now stored last, which may have moved in a sort
					if ({1'b0, rd_idx_q} == last_idx) last_key_q <= rk;
					if ((rk == qk_q) && !exact_q) begin
						exact_q <= 1'b1;
						exact_v_q <= rv;
					end
					if (rk < qk_q) begin
						lo_k_q <= rk;
						lo_v_q <= rv;
					end
					if ((rk > qk_q) && !hi_f_q) begin
						hi_f_q <= 1'b1;
						hi_k_q <= rk;
						hi_v_q <= rv;
					end
				end
			end
			CMD_EVAL: begin
				res_sat_q <= 1'b0;
				if (oob_q) begin
					res_val_q <= '0;
					res_st_q <= ST_OOB;
				end else if (exact_q) begin
					res_val_q <= exact_v_q;
					res_st_q <= ST_EXACT;
				end else begin
					res_st_q <= ST_INTERP;
				end
				dq_q <= DIFF_W'(qk_q) - DIFF_W'(lo_k_q);
				dv_q <= DIFF_W'(hi_v_q) - DIFF_W'(lo_v_q);
				den_q <= DIFF_W'(hi_k_q) - DIFF_W'(lo_k_q);
			end
			CMD_MUL: prod_q <= dq_q * dv_q;
			CMD_DIV_INIT: begin
				neg_q <= prod_q[PROD_W-1];
				dvd_q <= prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
				rem_q <= '0;
				dcnt_q <= '0;
			end
			CMD_DIV_STEP: begin
				rem_q <= tbit ? (trial - {1'b0, den_q}) : trial;
				dvd_q <= {dvd_q[MAG_W-2:0], tbit};
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			CMD_SUM: begin
				if (rsum > SUM_W'(32767)) begin
					res_val_q <= 16'sh7FFF;
					res_sat_q <= 1'b1;
				end else if (rsum < -SUM_W'(32768)) begin
					res_val_q <= -16'sh8000;
					res_sat_q <= 1'b1;
				end else begin
					res_val_q <= rsum[15:0];
				end
			end
			CMD_FINISH: begin
				out_val_q <= res_val_q;
				out_st_q <= res_st_q;
				out_sat_q <= res_sat_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_v_q;
	assign result_value = out_val_q;
	assign status = out_st_q;
	assign saturated = out_sat_q;

endmodule

// ===== hdl/piecewise_linear_table_lookup.sv =====
// Load, clear, unused opcodes and a query on an empty table: accepted while idle,
// result valid the next cycle; one item at a time, next accepted as the result drains.
// A query on an unordered table of n entries first runs a selection sort, one memory
// read a cycle. The lookup scan follows; an exact or out-of-range answer then goes to the
// output, while an interpolation first multiplies, runs the 33-step serial divider and adds.
// Reset (asynchronous, active low) empties the table and marks it ordered; memory is kept.
module piecewise_linear_table_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // entry_key, entry_value, query_key
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // result_value
	output logic [3:0]  m_axis_tuser   // status, saturated
);
	import plt_pkg::*;
	`include "assert_macros.svh"

	ctrl_t              ctrl;
	dp_stat_t           stat;
	logic signed [15:0] result_value;
	logic [2:0]         status;
	logic               saturated;
	logic               in_fire;

	plt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	plt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.opcode       (s_axis_tuser),
		.entry_key    (s_axis_tdata[15:0]),
		.entry_value  (s_axis_tdata[31:16]),
		.query_key    (s_axis_tdata[47:32]),
		.out_ready    (m_axis_tready),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.result_value (result_value),
		.status       (status),
		.saturated    (saturated)
	);

	assign s_axis_tready = ctrl.ready;
	assign m_axis_tdata = result_value;
	assign m_axis_tuser = {saturated, status};
	assign in_fire = s_axis_tvalid && s_axis_tready;

	`ASSERT_IMPL(a_ready_out_free, clk, arst_n, s_axis_tready, !m_axis_tvalid || m_axis_tready)
	`ASSERT_NEXT(a_quick_result, clk, arst_n, in_fire && (s_axis_tuser != OPC_QUERY), m_axis_tvalid)
	`ASSERT_IMPL(a_sat_interp, clk, arst_n, m_axis_tvalid && m_axis_tuser[3], m_axis_tuser[2:0] == ST_INTERP)

endmodule

// ===== tb/sv/piecewise_linear_table_lookup_checker.sv =====
// Scoreboard for the piecewise linear table lookup: watches both streams,
// predicts each result from its own copy of the table and compares in order.
// Depends on plt_pkg for opcodes, status codes and the table depth.
module piecewise_linear_table_lookup_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // entry_key, entry_value, query_key
	input  logic [1:0]  s_axis_tuser,  // opcode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // result_value
	input  logic [3:0]  m_axis_tuser,  // status, saturated
	output int          mismatch_count,
	output int          pending_results
);
	import plt_pkg::*;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  status;
		logic        saturated;
	} lookup_result_t;

	// Shadow copy of the breakpoint table
	logic signed [15:0] shadow_keys [TABLE_DEPTH];
	logic signed [15:0] shadow_vals [TABLE_DEPTH];
	int unsigned        shadow_count = 0;
	bit                 shadow_ordered = 1'b1;

	lookup_result_t expected_results[$];

	initial mismatch_count = 0;
	assign pending_results = expected_results.size();

	// Selection sort: swap position i with the first strictly smallest key from i on
	function automatic void order_table();
		int unsigned m;
		logic signed [15:0] tk, tv;
		for (int unsigned i = 0; i + 1 < shadow_count; i++) begin
			m = i;
			for (int unsigned j = i; j < shadow_count; j++)
				if (shadow_keys[j] < shadow_keys[m]) m = j;
			tk = shadow_keys[i]; shadow_keys[i] = shadow_keys[m]; shadow_keys[m] = tk;
			tv = shadow_vals[i]; shadow_vals[i] = shadow_vals[m]; shadow_vals[m] = tv;
		end
	endfunction

	// Apply one item to the shadow table and return the result it causes
	function automatic lookup_result_t table_step(logic [1:0] op, logic signed [15:0] ekey,
			logic signed [15:0] evalue, logic signed [15:0] qkey);
		lookup_result_t res;
		int unsigned pos;
		longint num, den, r;
		res = '{value: '0, status: ST_DONE, saturated: 1'b0};
		case (op)
			OPC_LOAD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (shadow_count > 0 && ekey < shadow_keys[shadow_count - 1])
						shadow_ordered = 1'b0;
					shadow_keys[shadow_count] = ekey;
					shadow_vals[shadow_count] = evalue;
					shadow_count++;
				end
			end
			OPC_CLEAR: begin
				shadow_count = 0;
				shadow_ordered = 1'b1;
			end
			OPC_QUERY: begin
				if (shadow_count == 0) return '{value: '0, status: ST_EMPTY, saturated: 1'b0};
				if (!shadow_ordered) begin
					order_table();
					shadow_ordered = 1'b1;
				end
				if (qkey > shadow_keys[shadow_count - 1] || qkey < shadow_keys[0])
					return '{value: '0, status: ST_OOB, saturated: 1'b0};
				for (int unsigned i = 0; i < shadow_count; i++)
					if (shadow_keys[i] == qkey)
						return '{value: shadow_vals[i], status: ST_EXACT, saturated: 1'b0};
				pos = 0;
				for (int unsigned i = 0; i < shadow_count; i++)
					if (qkey > shadow_keys[i]) pos = i;
				if (pos + 1 >= shadow_count)
					return '{value: '0, status: ST_OOB, saturated: 1'b0};
				den = longint'(shadow_keys[pos + 1]) - longint'(shadow_keys[pos]);
				if (den <= 0) return '{value: '0, status: ST_OOB, saturated: 1'b0};
				num = (longint'(qkey) - longint'(shadow_keys[pos])) *
				      (longint'(shadow_vals[pos + 1]) - longint'(shadow_vals[pos]));
				r = longint'(shadow_vals[pos]) + num / den;
				res.status = ST_INTERP;
				if (r > 32767) begin
					r = 32767;
					res.saturated = 1'b1;
				end else if (r < -32768) begin
					r = -32768;
					res.saturated = 1'b1;
				end
				res.value = r[15:0];
			end
			default: ;
		endcase
		return res;
	endfunction

	// Predict on each accepted input item, compare on each accepted result item
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.insert(expected_results.size(),
					table_step(s_axis_tuser, s_axis_tdata[15:0],
					s_axis_tdata[31:16], s_axis_tdata[47:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result_value: no result expected, got %0h", m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("result_value: expected %0h, got %0h", want.value, m_axis_tdata);
						mismatch_count++;
					end
					if (m_axis_tuser[2:0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:0]);
						mismatch_count++;
					end
					if (m_axis_tuser[3] !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							m_axis_tuser[3]);
						mismatch_count++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/piecewise_linear_table_lookup_test.sv =====
// Top of the table lookup testbench: clock, reset, stimulus and verdict.
// Depends on plt_pkg, the block and piecewise_linear_table_lookup_checker.
module piecewise_linear_table_lookup_test;
	import plt_pkg::*;

	localparam logic [1:0] OPC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT = 1_500_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // entry_key, entry_value, query_key
	logic [1:0]  s_axis_tuser = '0;  // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // result_value
	logic [3:0]  m_axis_tuser;       // status, saturated
	int          mismatch_count;
	int          pending_results;

	int          sender_idle_pct = 29;
	int          receiver_idle_pct = 87;
	int          items_sent = 0;
	int          cycle_count = 0;
	logic signed [15:0] loaded_keys[$];

	piecewise_linear_table_lookup dut (.*);

	piecewise_linear_table_lookup_checker scoreboard (.*);

	initial forever #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Random backpressure on the result stream
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

	// Present one item and hold it until accepted; idle afterward at random
	task automatic send_item(logic [1:0] op, logic [15:0] ekey, logic [15:0] evalue,
			logic [15:0] qkey);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {qkey, evalue, ekey};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		items_sent++;
		if (op == OPC_LOAD) loaded_keys.insert(loaded_keys.size(), ekey);
		if (op == OPC_CLEAR) loaded_keys.delete();
		if ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_query();
		logic signed [15:0] lo, hi;
		int sel;
		sel = $urandom_range(99);
		if (loaded_keys.size() == 0 || sel < 10) return 16'($urandom);
		if (sel < 40) return loaded_keys[$urandom_range(loaded_keys.size() - 1)];
		lo = loaded_keys[0];
		hi = loaded_keys[0];
		foreach (loaded_keys[i]) begin
			if (loaded_keys[i] < lo) lo = loaded_keys[i];
			if (loaded_keys[i] > hi) hi = loaded_keys[i];
		end
		return 16'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
	endfunction

	initial begin
		int n, style, base;
		logic [15:0] k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, unordered loads, duplicates, unused opcode
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h0);
		send_item(OPC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OPC_LOAD, 16'h8000, 16'h7FFF, 16'h0);
		send_item(OPC_LOAD, 16'h7FFF, 16'h8000, 16'h0);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h8000);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h7FFF);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h0000);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h7FFE);
		send_item(OPC_CLEAR, 16'h0, 16'h0, 16'h0);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'h0);
		send_item(OPC_LOAD, 16'd100, 16'h1000, 16'h0);
		send_item(OPC_LOAD, -16'sd100, 16'hF000, 16'h0);
		send_item(OPC_LOAD, 16'd0, 16'h0800, 16'h0);
		send_item(OPC_LOAD, 16'd0, 16'h0400, 16'h0);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'd0);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'd50);
		send_item(OPC_QUERY, 16'h0, 16'h0, -16'sd33);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'd101);
		send_item(OPC_QUERY, 16'h0, 16'h0, -16'sd101);
		send_item(OPC_QUERY, 16'h0, 16'h0, 16'd100);

		// Random: clear, load a table, query it; some noise items between
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > 2 * RANDOM_ITEMS / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end else if (items_sent > RANDOM_ITEMS / 3) begin
				sender_idle_pct = 87;
				receiver_idle_pct = 29;
			end
			if ($urandom_range(99) < 10) begin
				send_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				continue;
			end
			send_item(OPC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
			n = ($urandom_range(99) < 4) ? TABLE_DEPTH + $urandom_range(2)
				: $urandom_range(1, 10);
			style = $urandom_range(2);
			base = $urandom_range(200) - 100;
			for (int i = 0; i < n; i++) begin
				case (style)
					0: k = 16'($urandom);
					1: k = 16'($urandom_range(40) - 20);
					default: k = 16'(base + 37 * i + $urandom_range(20));
				endcase
				send_item(OPC_LOAD, k, 16'($urandom), 16'($urandom));
			end
			repeat ($urandom_range(2, 8))
				send_item(OPC_QUERY, 16'($urandom), 16'($urandom), pick_query());
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then allow for a late stray result
		wait (pending_results == 0);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
